### rtl/core/acg_pkg.sv
// acg_pkg: shared constants, codes and types of the alphabet candidate generator
// no dependencies; imported by acg_front, acg_back and alphabet_candidate_generator_core
package acg_pkg;

	// sizes
	localparam int MAX_LEN     = 16;
	localparam int LEN_W       = $clog2(MAX_LEN + 1);
	localparam int POS_W       = $clog2(MAX_LEN);
	localparam int ALPHA_DEPTH = 256;
	localparam int ADDR_W      = $clog2(ALPHA_DEPTH);
	localparam int SIZE_W      = $clog2(ALPHA_DEPTH + 1);
	localparam int CHAR_W      = 8;
	localparam int MAX_LANES   = 64;
	localparam int LANE_W      = $clog2(MAX_LANES + 1);
	localparam int CNT_W       = 48;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_SIZE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LANE_COUNT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LANE_NUMBER   = 3'd4;

	// command queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	// input function codes
	typedef enum logic [1:0] {
		FUNC_WRITE   = 2'd0,
		FUNC_NEXT    = 2'd1,
		FUNC_RESTART = 2'd2,
		FUNC_NOP     = 2'd3
	} func_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_CHAR      = 2'd0,
		ST_NONE      = 2'd1,
		ST_EXHAUSTED = 2'd2
	} status_t;

	// back end sequencer
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ADV,
		BK_CLASS,
		BK_RUN
	} back_state_t;

	typedef struct packed {
		func_t             op;
		logic [ADDR_W-1:0] idx;
		logic [CHAR_W-1:0] chr;
	} cmd_t;

	typedef struct packed {
		logic [LEN_W-1:0]  min_length;
		logic [LEN_W-1:0]  max_length;
		logic [SIZE_W-1:0] alphabet_size;
		logic [LANE_W-1:0] lane_count;
		logic [LANE_W-1:0] lane_number;
	} cfg_t;

	typedef struct packed {
		status_t           status;
		logic [POS_W-1:0]  pos;
		logic [LEN_W-1:0]  len;
		logic              last;
		logic [CNT_W-1:0]  cnt;
	} meta_t;

	typedef struct packed {
		meta_t             meta;
		logic [CHAR_W-1:0] chr;
	} res_t;

endpackage

### rtl/core/acg_front.sv
// acg_front: accepts input transactions, drops no-ops and queues commands for the back end
// depends on acg_pkg
module acg_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             func,
	input  logic [7:0]             alpha_index,
	input  logic [7:0]             alpha_char,
	input  logic                   pop,
	output logic                   head_valid,
	output acg_pkg::cmd_t          head
);
	import acg_pkg::*;

	cmd_t              q_mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop_ok;
	cmd_t              cmd;

	// classify the incoming transaction
	assign cmd.op   = func_t'(func);
	assign cmd.idx  = alpha_index;
	assign cmd.chr  = alpha_char;
	assign in_ready = (count_q != QCNT_W'(QDEPTH));
	assign push     = in_valid && in_ready && (cmd.op != FUNC_NOP);

	assign head_valid = (count_q != '0);
	assign head       = q_mem_q[rd_ptr_q];
	assign pop_ok     = pop && head_valid;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cmd;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop_ok) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop_ok) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (!push && pop_ok) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

### rtl/core/acg_back.sv
// acg_back: executes queued commands, advances the candidate counter and emits results
// depends on acg_pkg; holds the alphabet memory and the output register
module acg_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  acg_pkg::cfg_t          cfg,
	input  logic                   head_valid,
	input  acg_pkg::cmd_t          head,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output acg_pkg::res_t          res
);
	import acg_pkg::*;

	back_state_t       state_q;
	back_state_t       state_d;
	logic [7:0]        digit_q [MAX_LEN];
	logic [LEN_W-1:0]  len_q;
	logic [LANE_W-1:0] rotor_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              exh_q;
	logic [POS_W-1:0]  pos_q;
	logic [CHAR_W-1:0] mem [ALPHA_DEPTH];
	logic [CHAR_W-1:0] rd_data_q;
	logic              s1_valid_q;
	meta_t             meta_s1;
	logic              out_valid_q;
	res_t              out_q;

	logic              s1_free;
	logic              out_load;
	logic              mem_we;
	logic              do_restart;
	logic              do_adv;
	logic              rd_en;
	logic              s1_push;
	meta_t             meta_d;
	logic              rotor_upd;
	logic              cnt_upd;
	logic              last_pos;

	logic [SIZE_W-1:0] size_c;
	logic [LEN_W-1:0]  maxl_c;
	logic [LEN_W-1:0]  minl_c;
	logic [LANE_W-1:0] lc_c;
	logic [LANE_W-1:0] rotor_fix;
	logic [LANE_W-1:0] rotor_nx;
	logic              owned;
	logic [CNT_W-1:0]  cnt_inc;
	logic              hit;
	logic [POS_W-1:0]  hit_pos;
	logic [7:0]        adv_dig [MAX_LEN];
	logic [LEN_W-1:0]  adv_len;
	logic              adv_ok;

	// handshake between the read stage and the output register
	assign out_load  = s1_valid_q && (!out_valid_q || out_ready);
	assign s1_free   = !s1_valid_q || out_load;
	assign out_valid = out_valid_q;
	assign res       = out_q;

	// configuration clamps
	always_comb begin
		if (cfg.alphabet_size == '0) begin
			size_c = SIZE_W'(1);
		end else if (cfg.alphabet_size > SIZE_W'(ALPHA_DEPTH)) begin
			size_c = SIZE_W'(ALPHA_DEPTH);
		end else begin
			size_c = cfg.alphabet_size;
		end
		maxl_c = (cfg.max_length > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : cfg.max_length;
		minl_c = (cfg.min_length == '0) ? LEN_W'(1) : cfg.min_length;
		if (cfg.lane_count == '0) begin
			lc_c = LANE_W'(1);
		end else if (cfg.lane_count > LANE_W'(MAX_LANES)) begin
			lc_c = LANE_W'(MAX_LANES);
		end else begin
			lc_c = cfg.lane_count;
		end
	end

	// counter advance: rightmost digit that can still step, lower digits wrap
	always_comb begin
		hit     = 1'b0;
		hit_pos = '0;
		adv_len = len_q;
		adv_ok  = 1'b1;
		for (int i = 0; i < MAX_LEN; i++) begin
			if ((LEN_W'(i) < len_q) && (({1'b0, digit_q[i]} + SIZE_W'(1)) < size_c)) begin
				hit     = 1'b1;
				hit_pos = POS_W'(i);
			end
		end
		for (int i = 0; i < MAX_LEN; i++) begin
			adv_dig[i] = digit_q[i];
			if (!hit || (POS_W'(i) > hit_pos)) begin
				adv_dig[i] = '0;
			end else if (POS_W'(i) == hit_pos) begin
				adv_dig[i] = digit_q[i] + 8'd1;
			end
		end
		if (hit) begin
			adv_ok = (len_q <= maxl_c);
		end else if (len_q >= maxl_c) begin
			adv_ok = 1'b0;
		end else begin
			adv_len = len_q + LEN_W'(1);
		end
	end

	// lane rotor and attempt counter
	always_comb begin
		rotor_fix = ((rotor_q == '0) || (rotor_q > lc_c)) ? LANE_W'(1) : rotor_q;
		owned     = (rotor_fix == cfg.lane_number);
		rotor_nx  = (rotor_fix < lc_c) ? (rotor_fix + LANE_W'(1)) : LANE_W'(1);
		cnt_inc   = (cnt_q == '1) ? cnt_q : (cnt_q + CNT_W'(1));
		last_pos  = (({1'b0, pos_q} + LEN_W'(1)) == len_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (head_valid && (head.op == FUNC_NEXT)) begin
					state_d = BK_ADV;
				end
			end
			BK_ADV: begin
				state_d = BK_CLASS;
			end
			BK_CLASS: begin
				if (s1_free) begin
					if (exh_q || !owned || (len_q < minl_c)) begin
						state_d = BK_IDLE;
					end else begin
						state_d = BK_RUN;
					end
				end
			end
			BK_RUN: begin
				if (s1_free && last_pos) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		pop        = 1'b0;
		mem_we     = 1'b0;
		do_restart = 1'b0;
		do_adv     = 1'b0;
		rd_en      = 1'b0;
		s1_push    = 1'b0;
		rotor_upd  = 1'b0;
		cnt_upd    = 1'b0;
		meta_d     = '{status: ST_NONE, pos: '0, len: len_q, last: 1'b1, cnt: cnt_q};
		unique case (state_q)
			BK_IDLE: begin
				pop        = head_valid;
				mem_we     = head_valid && (head.op == FUNC_WRITE);
				do_restart = head_valid && (head.op == FUNC_RESTART);
			end
			BK_ADV: begin
				do_adv = !exh_q;
			end
			BK_CLASS: begin
				if (s1_free) begin
					if (exh_q) begin
						s1_push    = 1'b1;
						meta_d.status = ST_EXHAUSTED;
						meta_d.len = '0;
					end else if (!owned) begin
						s1_push   = 1'b1;
						rotor_upd = 1'b1;
					end else begin
						rotor_upd  = 1'b1;
						cnt_upd    = 1'b1;
						meta_d.cnt = cnt_inc;
						s1_push    = (len_q < minl_c);
					end
				end
			end
			BK_RUN: begin
				if (s1_free) begin
					rd_en         = 1'b1;
					s1_push       = 1'b1;
					meta_d.status = ST_CHAR;
					meta_d.pos    = pos_q;
					meta_d.last   = last_pos;
				end
			end
			default: ;
		endcase
	end

	// alphabet memory with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[head.idx] <= head.chr;
		end
		if (rd_en) begin
			rd_data_q <= mem[digit_q[pos_q]];
		end
	end

	// read stage and output register payload
	always_ff @(posedge clk) begin
		if (s1_push) begin
			meta_s1 <= meta_d;
		end
		if (out_load) begin
			out_q.meta <= meta_s1;
			out_q.chr  <= (meta_s1.status == ST_CHAR) ? rd_data_q : '0;
		end
	end

	// control and enumeration state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			len_q       <= '0;
			rotor_q     <= LANE_W'(1);
			cnt_q       <= '0;
			exh_q       <= 1'b0;
			pos_q       <= '0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_LEN; i++) begin
				digit_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (do_restart) begin
				len_q   <= '0;
				rotor_q <= LANE_W'(1);
				cnt_q   <= '0;
				exh_q   <= 1'b0;
				for (int i = 0; i < MAX_LEN; i++) begin
					digit_q[i] <= '0;
				end
			end
			if (do_adv) begin
				len_q <= adv_len;
				for (int i = 0; i < MAX_LEN; i++) begin
					digit_q[i] <= adv_dig[i];
				end
				if (!adv_ok) begin
					exh_q <= 1'b1;
				end
			end
			if (rotor_upd) begin
				rotor_q <= rotor_nx;
			end
			if (cnt_upd) begin
				cnt_q <= cnt_inc;
			end
			// character position walks from the first position
			if (state_q == BK_CLASS) begin
				pos_q <= '0;
			end else if (rd_en) begin
				pos_q <= pos_q + POS_W'(1);
			end
			if (s1_push) begin
				s1_valid_q <= 1'b1;
			end else if (out_load) begin
				s1_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/core/alphabet_candidate_generator_core.sv
// alphabet_candidate_generator_core: top level, configuration registers and assertions
// depends on acg_pkg, acg_front and acg_back
//
// channel  direction  handshake            payload
// in       input      in_valid/in_ready    func, alpha_index, alpha_char
// out      output     out_valid/out_ready  status, char_value, char_position, cand_length,
//                                          last_of_run, attempt_count
// cfg      input      cfg_we               cfg_index, cfg_data
//
// An alphabet write or restart is done in the back end as it is dequeued. A next request
// passes dequeue, counter advance and a lane and length check, then emits one character
// per cycle unless the output stalls, paced by the single alphabet memory read port.
// Results leave through a read stage and an output register, and a two-entry command
// queue lets the input side keep accepting while results wait on out_ready.
// Reset is asynchronous and needs no clearing pass; alphabet entries are undefined
// until written.
module alphabet_candidate_generator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [7:0]  alpha_index,
	input  logic [7:0]  alpha_char,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [7:0]  char_value,
	output logic [3:0]  char_position,
	output logic [4:0]  cand_length,
	output logic        last_of_run,
	output logic [47:0] attempt_count,
	input  logic        cfg_we,
	input  logic [acg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [acg_pkg::CFG_DATA_W-1:0] cfg_data
);
	import acg_pkg::*;

	cfg_t cfg_q;
	cmd_t head;
	logic head_valid;
	logic pop;
	res_t res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_length    <= LEN_W'(1);
			cfg_q.max_length    <= LEN_W'(16);
			cfg_q.alphabet_size <= SIZE_W'(62);
			cfg_q.lane_count    <= LANE_W'(1);
			cfg_q.lane_number   <= LANE_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MIN_LENGTH:    cfg_q.min_length    <= cfg_data[LEN_W-1:0];
				CFG_MAX_LENGTH:    cfg_q.max_length    <= cfg_data[LEN_W-1:0];
				CFG_ALPHABET_SIZE: cfg_q.alphabet_size <= cfg_data[SIZE_W-1:0];
				CFG_LANE_COUNT:    cfg_q.lane_count    <= cfg_data[LANE_W-1:0];
				CFG_LANE_NUMBER:   cfg_q.lane_number   <= cfg_data[LANE_W-1:0];
				default: ;
			endcase
		end
	end

	// front end: accept and queue
	acg_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.alpha_index (alpha_index),
		.alpha_char  (alpha_char),
		.pop         (pop),
		.head_valid  (head_valid),
		.head        (head)
	);

	// back end: enumerate and emit
	acg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.res        (res)
	);

	assign status        = res.meta.status;
	assign char_value    = res.chr;
	assign char_position = res.meta.pos;
	assign cand_length   = res.meta.len;
	assign last_of_run   = res.meta.last;
	assign attempt_count = res.meta.cnt;

`ifndef NO_ASSERTIONS
	// a candidate character lies inside its candidate
	a_char_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_CHAR)) |-> (char_position < cand_length))
		else $error("character position beyond candidate length");

	// status results are single and closing
	a_status_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != ST_CHAR)) |-> (last_of_run && (char_value == 8'd0)))
		else $error("status result not flagged last or carries a character");

	// exhausted results carry no length
	a_exhausted_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_EXHAUSTED)) |-> (cand_length == 5'd0))
		else $error("exhausted result with nonzero length");
`endif

endmodule

### tb/sv/tb_alphabet_candidate_generator_core.sv
// tb_alphabet_candidate_generator_core: self-checking testbench for the candidate generator
// depends on acg_pkg and alphabet_candidate_generator_core; holds its own enumeration predictor,
// drives directed and random request streams and checks every result transaction in order
module tb_alphabet_candidate_generator_core;
	import acg_pkg::*;

	localparam int RANDOM_ITEMS  = 110;
	localparam int SETTLE_CYCLES = 40;
	localparam int STALL_LIMIT   = 2000;

	// one expected result transaction
	typedef struct {
		status_t     st;
		logic [7:0]  chr;
		logic [3:0]  pos;
		logic [4:0]  len;
		logic        last;
		logic [47:0] cnt;
	} cand_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  func;
	logic [7:0]  alpha_index;
	logic [7:0]  alpha_char;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [7:0]  char_value;
	logic [3:0]  char_position;
	logic [4:0]  cand_length;
	logic        last_of_run;
	logic [47:0] attempt_count;
	logic        cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	int miss_count = 0;

	cand_result_t awaited_chars[$];

	// predictor state: enumeration counter, alphabet copy, lane rotor
	int          digit_at[MAX_LEN];
	int          cur_len;
	logic [7:0]  alpha_mem[ALPHA_DEPTH];
	int          rotor;
	logic [47:0] attempts;
	bit          spent;

	// predictor copy of the registers
	logic [4:0] min_cfg;
	logic [4:0] max_cfg;
	logic [8:0] size_cfg;
	logic [6:0] lanes_cfg;
	logic [6:0] lane_cfg;

	alphabet_candidate_generator_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.alpha_index(alpha_index),
		.alpha_char(alpha_char),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.char_value(char_value),
		.char_position(char_position),
		.cand_length(cand_length),
		.last_of_run(last_of_run),
		.attempt_count(attempt_count),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// enumeration restart
	function automatic void clear_counter();
		for (int k = 0; k < MAX_LEN; k++) digit_at[k] = 0;
		cur_len  = 0;
		rotor    = 1;
		attempts = '0;
		spent    = 1'b0;
	endfunction

	function automatic void push_result(status_t st, logic [7:0] ch, logic [3:0] pos,
			logic [4:0] len, logic last);
		cand_result_t r;
		r.st   = st;
		r.chr  = ch;
		r.pos  = pos;
		r.len  = len;
		r.last = last;
		r.cnt  = attempts;
		awaited_chars.push_back(r);
	endfunction

	// bijective base increment; returns 0 once past the longest length
	function automatic bit advance_counter();
		int size;
		int maxl;
		int i;
		size = int'(size_cfg);
		if (size == 0) size = 1;
		if (size > ALPHA_DEPTH) size = ALPHA_DEPTH;
		maxl = int'(max_cfg);
		if (maxl > MAX_LEN) maxl = MAX_LEN;
		if (cur_len > MAX_LEN) cur_len = MAX_LEN;
		i = cur_len;
		while (i > 0) begin
			i--;
			if (digit_at[i] + 1 < size) begin
				digit_at[i]++;
				return cur_len <= maxl;
			end
			digit_at[i] = 0;
		end
		// carry out of the first position grows the length
		if (cur_len >= maxl) return 1'b0;
		cur_len++;
		for (i = 0; i < cur_len; i++) digit_at[i] = 0;
		return 1'b1;
	endfunction

	// expected results of one accepted input transaction
	function automatic void enumerate_step(func_t f, logic [7:0] idx, logic [7:0] chr);
		int  lc;
		int  minl;
		int  k;
		bit  mine;
		case (f)
			FUNC_WRITE: begin
				alpha_mem[idx] = chr;
			end
			FUNC_RESTART: begin
				clear_counter();
			end
			FUNC_NEXT: begin
				if (!spent && !advance_counter()) spent = 1'b1;
				if (spent) begin
					push_result(ST_EXHAUSTED, 8'd0, 4'd0, 5'd0, 1'b1);
					return;
				end
				// round robin ownership
				lc = int'(lanes_cfg);
				if (lc == 0) lc = 1;
				if (lc > MAX_LANES) lc = MAX_LANES;
				if (rotor < 1 || rotor > lc) rotor = 1;
				mine  = (rotor == int'(lane_cfg));
				rotor = (rotor < lc) ? rotor + 1 : 1;
				if (!mine) begin
					push_result(ST_NONE, 8'd0, 4'd0, 5'(cur_len), 1'b1);
					return;
				end
				if (attempts != '1) attempts++;
				minl = (min_cfg == 5'd0) ? 1 : int'(min_cfg);
				if (cur_len < minl) begin
					push_result(ST_NONE, 8'd0, 4'd0, 5'(cur_len), 1'b1);
					return;
				end
				for (k = 0; k < cur_len; k++)
					push_result(ST_CHAR, alpha_mem[8'(digit_at[k])], 4'(k), 5'(cur_len),
						k + 1 == cur_len);
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void log_miss(string msg);
		miss_count++;
		if (miss_count <= 10) $display("%s", msg);
	endfunction

	// one input transaction with a random lead-in gap
	task automatic send_item(input func_t f, input logic [7:0] idx, input logic [7:0] chr);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 6);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		func        <= f;
		alpha_index <= idx;
		alpha_char  <= chr;
		do @(posedge clk); while (!in_ready);
		enumerate_step(f, idx, chr);
	endtask

	// stop sending, let every expected result arrive, then let the back end settle
	task automatic wait_for_quiet();
		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited_chars.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_MIN_LENGTH:    min_cfg   = val[4:0];
			CFG_MAX_LENGTH:    max_cfg   = val[4:0];
			CFG_ALPHABET_SIZE: size_cfg  = val;
			CFG_LANE_COUNT:    lanes_cfg = val[6:0];
			CFG_LANE_NUMBER:   lane_cfg  = val[6:0];
			default: begin
			end
		endcase
	endtask

	task automatic configure(input logic [8:0] mn, input logic [8:0] mx, input logic [8:0] sz,
			input logic [8:0] lc, input logic [8:0] ln);
		set_reg(CFG_MIN_LENGTH, mn);
		set_reg(CFG_MAX_LENGTH, mx);
		set_reg(CFG_ALPHABET_SIZE, sz);
		set_reg(CFG_LANE_COUNT, lc);
		set_reg(CFG_LANE_NUMBER, ln);
	endtask

	// every alphabet entry is written once so no read ever hits an unwritten entry
	task automatic load_alphabet();
		int         i;
		logic [7:0] chr;
		for (i = 0; i < ALPHA_DEPTH; i++) begin
			tx_calm = (i >= 128);
			if (i == 0) chr = 8'h00;
			else if (i == 1) chr = 8'hFF;
			else chr = 8'($urandom_range(0, 255));
			send_item(FUNC_WRITE, 8'(i), chr);
		end
		tx_calm = 1'b0;
		wait_for_quiet();
	endtask

	// reset values: length one candidates, no-op and restart
	task automatic test_first_candidates();
		send_item(FUNC_NEXT, 8'h00, 8'h00);
		send_item(FUNC_NEXT, 8'hFF, 8'hFF);
		send_item(FUNC_NOP, 8'h5A, 8'hA5);
		send_item(FUNC_RESTART, 8'h00, 8'h00);
		send_item(FUNC_NEXT, 8'h00, 8'h00);
		wait_for_quiet();
	endtask

	// short enumeration runs out, requests after that report exhausted
	task automatic test_exhaustion();
		configure(9'd1, 9'd1, 9'd2, 9'd1, 9'd1);
		send_item(FUNC_RESTART, 8'h00, 8'h00);
		repeat (4) send_item(FUNC_NEXT, 8'h00, 8'h00);
		wait_for_quiet();
	endtask

	// two lanes, this one owns every second candidate
	task automatic test_lane_sharing();
		configure(9'd1, 9'd16, 9'd62, 9'd2, 9'd2);
		send_item(FUNC_RESTART, 8'h00, 8'h00);
		repeat (3) send_item(FUNC_NEXT, 8'h00, 8'h00);
		wait_for_quiet();
	endtask

	// zero and all-ones register values
	task automatic test_register_extremes();
		configure(9'd0, 9'd0, 9'd0, 9'd0, 9'd0);
		send_item(FUNC_RESTART, 8'h00, 8'h00);
		repeat (2) send_item(FUNC_NEXT, 8'h00, 8'h00);
		wait_for_quiet();
		configure(9'd31, 9'd31, 9'd511, 9'd127, 9'd127);
		send_item(FUNC_RESTART, 8'h00, 8'h00);
		repeat (2) send_item(FUNC_NEXT, 8'h00, 8'h00);
		wait_for_quiet();
	endtask

	// shrinking alphabet and max length without a restart
	task automatic test_reconfig_midrun();
		configure(9'd1, 9'd3, 9'd3, 9'd1, 9'd1);
		send_item(FUNC_RESTART, 8'h00, 8'h00);
		repeat (3) send_item(FUNC_NEXT, 8'h00, 8'h00);
		wait_for_quiet();
		// last digit now at or above the size, so it carries
		set_reg(CFG_ALPHABET_SIZE, 9'd2);
		send_item(FUNC_NEXT, 8'h00, 8'h00);
		wait_for_quiet();
		// current length above max length exhausts
		set_reg(CFG_MAX_LENGTH, 9'd1);
		send_item(FUNC_NEXT, 8'h00, 8'h00);
		wait_for_quiet();
	endtask

	// random settings, mostly well formed request runs with some noise
	task automatic test_random_runs();
		int         sent;
		int         n;
		int         pick;
		logic [8:0] sz;
		logic [8:0] mx;
		logic [8:0] mn;
		logic [8:0] lc;
		logic [8:0] ln;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			wait_for_quiet();
			pick = $urandom_range(0, 9);
			if (pick == 0) sz = 9'd1;
			else if (pick < 6) sz = 9'($urandom_range(2, 4));
			else if (pick < 8) sz = 9'($urandom_range(5, 62));
			else if (pick == 8) sz = 9'd256;
			else sz = 9'($urandom_range(0, 511));
			mx = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(0, 31)) :
				9'($urandom_range(1, 16));
			mn = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(0, 31)) :
				9'($urandom_range(1, 4));
			lc = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 127)) :
				9'($urandom_range(1, 3));
			if ($urandom_range(0, 5) == 0)
				ln = 9'($urandom_range(0, 127));
			else
				ln = 9'($urandom_range(1, (lc == 9'd0) ? 1 :
					((lc > 9'd64) ? 64 : int'(lc))));
			configure(mn, mx, sz, lc, ln);
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			// most runs start over, some continue from the old counter
			if ($urandom_range(0, 3) != 0) begin
				send_item(FUNC_RESTART, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
				sent++;
			end
			n = $urandom_range(15, 50);
			repeat (n) begin
				pick = $urandom_range(0, 99);
				if (pick < 78) begin
					send_item(FUNC_NEXT, 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)));
				end else if (pick < 88) begin
					send_item(FUNC_WRITE, 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)));
				end else if (pick < 93) begin
					send_item(FUNC_RESTART, 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)));
				end else begin
					send_item(FUNC_NOP, 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)));
				end
				sent++;
				// occasional hold-off until the output side has caught up
				if ($urandom_range(0, 39) == 0) wait_for_quiet();
			end
		end
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		wait_for_quiet();
	endtask

	// output side: random stall before taking each result transaction
	initial begin : result_sink
		int stall;
		out_ready = 1'b0;
		forever begin
			stall = rx_calm ? 0 : $urandom_range(0, 6);
			repeat (stall) begin
				@(negedge clk);
				out_ready <= 1'b0;
			end
			@(negedge clk);
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// compare each result transaction with the oldest expectation
	always @(posedge clk) begin : result_check
		cand_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_chars.size() == 0) begin
				log_miss($sformatf("unexpected result: st=%0d chr=%02h pos=%0d len=%0d last=%0d cnt=%0d",
					status, char_value, char_position, cand_length, last_of_run, attempt_count));
			end else begin
				want = awaited_chars.pop_front();
				if (status !== want.st || char_value !== want.chr || char_position !== want.pos ||
						cand_length !== want.len || last_of_run !== want.last ||
						attempt_count !== want.cnt)
					log_miss($sformatf({"result mismatch: expected st=%0d chr=%02h pos=%0d len=%0d ",
						"last=%0d cnt=%0d, got st=%0d chr=%02h pos=%0d len=%0d last=%0d cnt=%0d"},
						want.st, want.chr, want.pos, want.len, want.last, want.cnt,
						status, char_value, char_position, cand_length, last_of_run,
						attempt_count));
			end
		end
	end

	// end the run when nothing moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
			else quiet++;
		end
		$display("Verification failed");
		$finish;
	end

	// test sequence
	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		func        = FUNC_NOP;
		alpha_index = '0;
		alpha_char  = '0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		min_cfg     = 5'd1;
		max_cfg     = 5'd16;
		size_cfg    = 9'd62;
		lanes_cfg   = 7'd1;
		lane_cfg    = 7'd1;
		for (int k = 0; k < ALPHA_DEPTH; k++) alpha_mem[k] = 8'h00;
		clear_counter();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		load_alphabet();
		test_first_candidates();
		test_exhaustion();
		test_lane_sharing();
		test_register_extremes();
		test_reconfig_midrun();
		test_random_runs();

		if (miss_count == 0 && awaited_chars.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
